// ----- src/mecanum_forward_kinematics_unit_macros.svh -----
`ifndef MECANUM_FORWARD_KINEMATICS_UNIT_MACROS_SVH
`define MECANUM_FORWARD_KINEMATICS_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MFK_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mfk_pkg.sv -----
`default_nettype none

package mfk_pkg;

	localparam int GAIN_W     = 16;
	localparam int SPD_W      = 16;
	localparam int SUM_W      = SPD_W + 2;
	localparam int PROD_W     = SUM_W + GAIN_W + 1;
	localparam int RND_W      = PROD_W + 1;
	localparam int FRAC_SHIFT = 12;
	localparam int OUT_W      = 24;
	localparam int ROOT_W     = OUT_W;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int IN_TW      = 4 * SPD_W;
	localparam int OUT_TW     = 4 * OUT_W;

	localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST   = GAIN_W'(6434);
	localparam logic [GAIN_W-1:0] ROTATION_GAIN_RST = GAIN_W'(6434);

	typedef enum logic [0:0] {
		REG_LINEAR_GAIN   = 1'b0,
		REG_ROTATION_GAIN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] vx;
		logic signed [OUT_W-1:0] vy;
		logic signed [OUT_W-1:0] w;
	} body_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		body_t body;
		sqrt_t sq;
	} cell_t;

endpackage

`default_nettype wire

// ----- src/mfk_front.sv -----
`default_nettype none

module mfk_front
	import mfk_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire signed [SPD_W-1:0]  fl,
	input  wire signed [SPD_W-1:0]  fr,
	input  wire signed [SPD_W-1:0]  bl,
	input  wire signed [SPD_W-1:0]  br,
	input  wire        [GAIN_W-1:0] linear_gain,
	input  wire        [GAIN_W-1:0] rotation_gain,
	output logic                    out_valid,
	input  wire                     out_ready,
	output cell_t                   out_word
);

	localparam int RND_HALF = 1 << (FRAC_SHIFT - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic r_s1, r_s2, r_s3, r_s4, r_s5;

	logic signed [SUM_W-1:0]  sx_s1, sy_s1, sw_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2, pw_s2;
	body_t                    body_s3, body_s4;
	logic        [RAD_W-1:0]  sqx_s4, sqy_s4;
	cell_t                    word_s5;

	logic signed [RND_W-1:0] tx, ty, tw;
	logic        [OUT_W-1:0] ax, ay;

	assign r_s5     = !v_s5 || out_ready;
	assign r_s4     = !v_s4 || r_s5;
	assign r_s3     = !v_s3 || r_s4;
	assign r_s2     = !v_s2 || r_s3;
	assign r_s1     = !v_s1 || r_s2;
	assign in_ready = r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= in_valid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3) v_s3 <= v_s2;
			if (r_s4) v_s4 <= v_s3;
			if (r_s5) v_s5 <= v_s4;
		end
	end

	// round half up, then floor by the Q.12 gain fraction; range fits 24 bits
	assign tx = RND_W'(px_s2) + RND_W'(RND_HALF);
	assign ty = RND_W'(py_s2) + RND_W'(RND_HALF);
	assign tw = RND_W'(pw_s2) + RND_W'(RND_HALF);

	assign ax = body_s3.vx[OUT_W-1] ? (~body_s3.vx + 1'b1) : body_s3.vx;
	assign ay = body_s3.vy[OUT_W-1] ? (~body_s3.vy + 1'b1) : body_s3.vy;

	always_ff @(posedge clk) begin
		if (r_s1) begin
			sx_s1 <= SUM_W'(fl) + SUM_W'(fr) + SUM_W'(bl) + SUM_W'(br);
			sy_s1 <= SUM_W'(fr) + SUM_W'(bl) - SUM_W'(fl) - SUM_W'(br);
			sw_s1 <= SUM_W'(fr) + SUM_W'(br) - SUM_W'(fl) - SUM_W'(bl);
		end
		if (r_s2) begin
			px_s2 <= PROD_W'(sx_s1) * PROD_W'($signed({1'b0, linear_gain}));
			py_s2 <= PROD_W'(sy_s1) * PROD_W'($signed({1'b0, linear_gain}));
			pw_s2 <= PROD_W'(sw_s1) * PROD_W'($signed({1'b0, rotation_gain}));
		end
		if (r_s3) begin
			body_s3.vx <= tx[RND_W-1:FRAC_SHIFT];
			body_s3.vy <= ty[RND_W-1:FRAC_SHIFT];
			body_s3.w  <= tw[RND_W-1:FRAC_SHIFT];
		end
		if (r_s4) begin
			body_s4 <= body_s3;
			sqx_s4  <= RAD_W'(ax) * RAD_W'(ax);
			sqy_s4  <= RAD_W'(ay) * RAD_W'(ay);
		end
		if (r_s5) begin
			word_s5.body    <= body_s4;
			word_s5.sq.rad  <= sqx_s4 + sqy_s4;
			word_s5.sq.rem  <= '0;
			word_s5.sq.root <= '0;
		end
	end

	assign out_valid = v_s5;
	assign out_word  = word_s5;

endmodule

`default_nettype wire

// ----- src/mfk_sqrt_cell.sv -----
`default_nettype none
`include "mecanum_forward_kinematics_unit_macros.svh"

module mfk_sqrt_cell
	import mfk_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire cell_t in_word,
	output logic       out_valid,
	input  wire        out_ready,
	output cell_t      out_word
);

	logic  v_q;
	cell_t word_q;

	logic [REM_W-1:0] rem2;
	logic [REM_W-1:0] trial;
	logic             ge;
	cell_t            nxt;

	assign in_ready = !v_q || out_ready;

	// one root bit per cell: bring down two radicand bits, try root*4+1
	assign rem2  = {in_word.sq.rem[REM_W-3:0], in_word.sq.rad[RAD_W-1 -: 2]};
	assign trial = {in_word.sq.root, 2'b01};
	assign ge    = rem2 >= trial;

	always_comb begin
		nxt         = in_word;
		nxt.sq.rad  = {in_word.sq.rad[RAD_W-3:0], 2'b00};
		nxt.sq.rem  = ge ? (rem2 - trial) : rem2;
		nxt.sq.root = {in_word.sq.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) word_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_word  = word_q;

	`MFK_ASSERT_NEXT(a_cell_hold, v_q && !out_ready, v_q && $stable(word_q), "stalled word lost")
	`MFK_ASSERT(a_cell_rem, v_q, (word_q.sq.rem <= {1'b0, word_q.sq.root, 1'b0}), "rem too large")
	`MFK_ASSERT(a_cell_rad, v_q, word_q.sq.rad[1:0] == 2'b00, "radicand not shifted")

endmodule

`default_nettype wire

// ----- src/mecanum_forward_kinematics_unit.sv -----
`default_nettype none
`include "mecanum_forward_kinematics_unit_macros.svh"

// Mecanum base forward kinematics. Takes one word of four Q8.8 wheel speeds per
// cycle and returns forward, lateral and rotation velocity plus signed speed, all
// Q16.8. The path holds five stages of sums, gain products, rounding and squares,
// 24 square-root cells that each settle one root bit, and the output
// register. Throughput is one word per clock; a stalled output holds the chain
// back stage by stage, filling bubbles first. Gains are sampled by the product
// stage and take effect for words that reach it after the write.

module mecanum_forward_kinematics_unit
	import mfk_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	// front_left_speed, front_right_speed, back_left_speed, back_right_speed
	input  wire  [IN_TW-1:0]   s_tdata,
	output logic               m_tvalid,
	input  wire                m_tready,
	// forward_velocity, lateral_velocity, rotation_rate, signed_speed
	output logic [OUT_TW-1:0]  m_tdata,
	input  wire                cfg_we,
	input  wire  [0:0]         cfg_addr,
	input  wire  [GAIN_W-1:0]  cfg_data
);

	localparam logic [ROOT_W:0] MAG_POS_MAX = (ROOT_W+1)'((1 << (OUT_W - 1)) - 1);
	localparam logic [ROOT_W:0] MAG_NEG_MAX = (ROOT_W+1)'(1 << (OUT_W - 1));

	logic [GAIN_W-1:0] linear_gain_q, rotation_gain_q;

	cell_t chain_w [0:ROOT_W];
	logic  chain_v [0:ROOT_W];
	logic  chain_r [0:ROOT_W];

	cell_t              last;
	logic  [ROOT_W:0]   mag;
	logic  [OUT_W-1:0]  sp;
	logic               out_ld;
	logic               m_tvalid_q;
	logic  [OUT_TW-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_gain_q   <= LINEAR_GAIN_RST;
			rotation_gain_q <= ROTATION_GAIN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_LINEAR_GAIN:   linear_gain_q   <= cfg_data;
				REG_ROTATION_GAIN: rotation_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mfk_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.fl            ($signed(s_tdata[SPD_W-1:0])),
		.fr            ($signed(s_tdata[2*SPD_W-1:SPD_W])),
		.bl            ($signed(s_tdata[3*SPD_W-1:2*SPD_W])),
		.br            ($signed(s_tdata[4*SPD_W-1:3*SPD_W])),
		.linear_gain   (linear_gain_q),
		.rotation_gain (rotation_gain_q),
		.out_valid     (chain_v[0]),
		.out_ready     (chain_r[0]),
		.out_word      (chain_w[0])
	);

	for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
		mfk_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[g]),
			.in_ready  (chain_r[g]),
			.in_word   (chain_w[g]),
			.out_valid (chain_v[g+1]),
			.out_ready (chain_r[g+1]),
			.out_word  (chain_w[g+1])
		);
	end

	assign last   = chain_w[ROOT_W];
	assign out_ld = !m_tvalid_q || m_tready;
	assign chain_r[ROOT_W] = out_ld;

	// round to nearest, sign from forward velocity, clamp to 24 bits
	always_comb begin
		mag = {1'b0, last.sq.root} + (ROOT_W+1)'(last.sq.rem > REM_W'(last.sq.root));
		if (last.body.vx[OUT_W-1]) begin
			if (mag > MAG_NEG_MAX) sp = {1'b1, {(OUT_W-1){1'b0}}};
			else                   sp = OUT_W'(~mag + 1'b1);
		end else begin
			if (mag > MAG_POS_MAX) sp = {1'b0, {(OUT_W-1){1'b1}}};
			else                   sp = OUT_W'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= chain_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) m_tdata_q <= {sp, last.body.w, last.body.vy, last.body.vx};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`MFK_ASSERT(a_sp_neg, m_tvalid_q && m_tdata_q[OUT_TW-1], m_tdata_q[OUT_W-1], "negative speed with forward velocity not negative")
	`MFK_ASSERT(a_sp_pos, m_tvalid_q && !m_tdata_q[OUT_W-1], !m_tdata_q[OUT_TW-1], "speed sign mismatch")

endmodule

`default_nettype wire

// ----- tb/mecanum_forward_kinematics_unit_test.sv -----
`default_nettype none

module mecanum_forward_kinematics_unit_test;
	import mfk_pkg::*;

	localparam int LONG_HOLD   = 150;
	localparam int DRAIN_WAIT  = 40;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_WORDS = 70;
	localparam int PHASES      = 6;

	typedef struct packed {
		logic signed [SPD_W-1:0] br;
		logic signed [SPD_W-1:0] bl;
		logic signed [SPD_W-1:0] fr;
		logic signed [SPD_W-1:0] fl;
	} wheel_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] sp;
		logic signed [OUT_W-1:0] w;
		logic signed [OUT_W-1:0] vy;
		logic signed [OUT_W-1:0] vx;
	} body_motion_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	wire                 s_tready;
	// front_left_speed, front_right_speed, back_left_speed, back_right_speed
	logic [IN_TW-1:0]    s_tdata = '0;
	wire                 m_tvalid;
	logic                m_tready = 1'b0;
	// forward_velocity, lateral_velocity, rotation_rate, signed_speed
	wire  [OUT_TW-1:0]   m_tdata;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_addr = '0;
	logic [GAIN_W-1:0]   cfg_data = '0;

	mecanum_forward_kinematics_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [GAIN_W-1:0] lin_gain = LINEAR_GAIN_RST;
	logic [GAIN_W-1:0] rot_gain = ROTATION_GAIN_RST;

	wheel_word_t  wheel_backlog[$];
	body_motion_t motion_expected[$];

	int err_count = 0;
	bit word_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int ready_gap;
	int hold_requests = 0;
	int holds_done = 0;
	bit sender_steady = 1'b0;
	bit receiver_steady = 1'b0;

	function automatic longint clamp_out(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	// Q.20 product rounded to Q.8, ties toward plus infinity
	function automatic longint apply_gain(longint sum, logic [GAIN_W-1:0] gain);
		longint t;
		t = sum * longint'({48'd0, gain}) + 64'sd2048;
		return clamp_out(t >>> FRAC_SHIFT);
	endfunction

	function automatic longint rounded_root(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned n;
		res = 0;
		bitv = 64'd1 << 62;
		n = v;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		if (n > res)
			res = res + 1;
		return longint'(res);
	endfunction

	function automatic body_motion_t predict_body_motion(wheel_word_t ws);
		longint fl, fr, bl, br;
		longint vx, vy, w, ax, ay, mag;
		body_motion_t r;
		fl = ws.fl;
		fr = ws.fr;
		bl = ws.bl;
		br = ws.br;
		vx = apply_gain(fl + fr + bl + br, lin_gain);
		vy = apply_gain(-fl + fr + bl - br, lin_gain);
		w  = apply_gain(-fl + fr - bl + br, rot_gain);
		ax = (vx < 0) ? -vx : vx;
		ay = (vy < 0) ? -vy : vy;
		mag = rounded_root(longint'(ax * ax + ay * ay));
		r.vx = vx[OUT_W-1:0];
		r.vy = vy[OUT_W-1:0];
		r.w  = w[OUT_W-1:0];
		mag = clamp_out((vx < 0) ? -mag : mag);
		r.sp = mag[OUT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [SPD_W-1:0] rand_speed();
		int r;
		r = $urandom_range(9);
		case (r)
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(2)) - 1);
			3, 4: return 16'(int'($urandom_range(1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic wheel_word_t make_wheels(int fl, int fr, int bl, int br);
		wheel_word_t ws;
		ws.fl = 16'(fl);
		ws.fr = 16'(fr);
		ws.bl = 16'(bl);
		ws.br = 16'(br);
		return ws;
	endfunction

	task automatic report_mismatch(string field, logic [OUT_W-1:0] got,
			logic [OUT_W-1:0] want);
		$display("mismatch %s: got %h expected %h", field, got, want);
		err_count++;
	endtask

	task automatic write_gain(reg_idx_t idx, logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LINEAR_GAIN)
			lin_gain = val;
		else
			rot_gain = val;
	endtask

	task automatic wait_for_drain();
		while (wheel_backlog.size() != 0 || motion_expected.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (wheel_backlog.size() != 0) begin
				s_tdata <= wheel_backlog.pop_front();
				s_tvalid <= 1'b1;
				send_gap = pick_gap(sender_steady);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		word_taken = 1'b0;
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_requests != holds_done) begin
			holds_done = hold_requests;
			stall_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			ready_gap = pick_gap(receiver_steady);
			if (ready_gap == 0) begin
				m_tready <= 1'b1;
			end else begin
				stall_left = ready_gap - 1;
				m_tready <= 1'b0;
			end
		end
	end

	// accepted words in, results checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				motion_expected.push_back(predict_body_motion(wheel_word_t'(s_tdata)));
				word_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				body_motion_t got, want;
				got = body_motion_t'(m_tdata);
				if (motion_expected.size() == 0) begin
					report_mismatch("unexpected word", got.vx, '0);
				end else begin
					want = motion_expected.pop_front();
					if (got.vx !== want.vx)
						report_mismatch("forward_velocity", got.vx, want.vx);
					if (got.vy !== want.vy)
						report_mismatch("lateral_velocity", got.vy, want.vy);
					if (got.w !== want.w)
						report_mismatch("rotation_rate", got.w, want.w);
					if (got.sp !== want.sp)
						report_mismatch("signed_speed", got.sp, want.sp);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet = quiet + 1;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at reset gains
		wheel_backlog.push_back(make_wheels(0, 0, 0, 0));
		wheel_backlog.push_back(make_wheels(32767, 32767, 32767, 32767));
		wheel_backlog.push_back(make_wheels(-32768, -32768, -32768, -32768));
		wheel_backlog.push_back(make_wheels(-32768, 32767, 32767, -32768));
		wheel_backlog.push_back(make_wheels(32767, -32768, -32768, 32767));
		wheel_backlog.push_back(make_wheels(-32768, 32767, -32768, 32767));
		wheel_backlog.push_back(make_wheels(32767, -32768, 32767, -32768));
		wheel_backlog.push_back(make_wheels(1, 0, 0, 0));
		wheel_backlog.push_back(make_wheels(-1, 0, 0, 0));
		wheel_backlog.push_back(make_wheels(0, 0, 0, -1));
		// zero forward, negative lateral
		wheel_backlog.push_back(make_wheels(1, -1, -1, 1));
		// negative forward, positive lateral
		wheel_backlog.push_back(make_wheels(-256, 0, 0, -256));
		wheel_backlog.push_back(make_wheels(32767, -32768, 0, 0));
		wheel_backlog.push_back(make_wheels(-1, -1, -1, -1));
		wait_for_drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_gain(REG_LINEAR_GAIN, 16'hFFFF);
					write_gain(REG_ROTATION_GAIN, 16'hFFFF);
				end
				1: begin
					write_gain(REG_LINEAR_GAIN, 16'h0000);
					write_gain(REG_ROTATION_GAIN, 16'h0000);
				end
				2: begin
					write_gain(REG_LINEAR_GAIN, 16'd1);
					write_gain(REG_ROTATION_GAIN, 16'hFFFF);
				end
				3: begin
					write_gain(REG_LINEAR_GAIN, 16'hFFFF);
					write_gain(REG_ROTATION_GAIN, 16'd1);
				end
				default: begin
					write_gain(REG_LINEAR_GAIN, 16'($urandom));
					write_gain(REG_ROTATION_GAIN, 16'($urandom));
				end
			endcase
			sender_steady = (ph == 2 || ph == 4);
			receiver_steady = (ph == 4);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				wheel_word_t ws;
				ws.fl = rand_speed();
				ws.fr = rand_speed();
				ws.bl = rand_speed();
				ws.br = rand_speed();
				wheel_backlog.push_back(ws);
			end
			// long output stall while input keeps coming
			if (ph == 2)
				hold_requests = hold_requests + 1;
			wait_for_drain();
		end

		if (err_count == 0 && motion_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/mfk_pkg.sv
src/mfk_front.sv
src/mfk_sqrt_cell.sv
src/mecanum_forward_kinematics_unit.sv
tb/mecanum_forward_kinematics_unit_test.sv
